// ===== hdl/sssp_pkg.sv =====
// shared types, constants and codes for the shortest path core
package sssp_pkg;

  localparam int MAX_NODES_DEF   = 32;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int NODE_W      = 5;
  localparam int WEIGHT_IN_W = 16;
  localparam int OUT_DIST_W  = 21;
  localparam int CFG_W       = 6;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(32);

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_RUN   = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic [NODE_W-1:0]        from_node;
    logic [NODE_W-1:0]        to_node;
    logic [WEIGHT_IN_W-1:0]   edge_weight;
    logic                     edge_present;
    logic [NODE_W-1:0]        source_node;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]     node_id;
    logic [OUT_DIST_W-1:0] distance;
    logic                  reachable;
    logic [NODE_W-1:0]     predecessor;
    logic                  last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_PICK,
    ST_RLX_RD,
    ST_RLX_CMP,
    ST_OUT_RD,
    ST_OUT_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic clear_wr;
    logic write_edge;
    logic run_init;
    logic scan_cmp;
    logic pick;
    logic relax_cmp;
    logic out_emit;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic src_ok;
    logic found;
    logic idx_last;
  } dp_sts_t;

endpackage

// ===== hdl/sssp_ram.sv =====
// generic single write port ram with registered read
module sssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sssp_ctrl.sv =====
// sequencing state machine: clear pass, scan, pick, relax and result output
module sssp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  sssp_pkg::opcode_t opcode,
  input  sssp_pkg::dp_sts_t sts,
  output sssp_pkg::dp_cmd_t cmd,
  output logic              busy
);

  sssp_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sssp_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sssp_pkg::ST_CLEAR: begin
        if (sts.clear_done) state_nxt = sssp_pkg::ST_IDLE;
      end
      sssp_pkg::ST_IDLE: begin
        if (start && opcode == sssp_pkg::OP_RUN) begin
          state_nxt = sts.src_ok ? sssp_pkg::ST_SCAN_RD : sssp_pkg::ST_OUT_RD;
        end
      end
      sssp_pkg::ST_SCAN_RD:  state_nxt = sssp_pkg::ST_SCAN_CMP;
      sssp_pkg::ST_SCAN_CMP: begin
        state_nxt = sts.idx_last ? sssp_pkg::ST_PICK : sssp_pkg::ST_SCAN_RD;
      end
      sssp_pkg::ST_PICK: begin
        state_nxt = sts.found ? sssp_pkg::ST_RLX_RD : sssp_pkg::ST_OUT_RD;
      end
      sssp_pkg::ST_RLX_RD:   state_nxt = sssp_pkg::ST_RLX_CMP;
      sssp_pkg::ST_RLX_CMP: begin
        state_nxt = sts.idx_last ? sssp_pkg::ST_SCAN_RD : sssp_pkg::ST_RLX_RD;
      end
      sssp_pkg::ST_OUT_RD:   state_nxt = sssp_pkg::ST_OUT_EMIT;
      sssp_pkg::ST_OUT_EMIT: begin
        state_nxt = sts.idx_last ? sssp_pkg::ST_IDLE : sssp_pkg::ST_OUT_RD;
      end
      default: state_nxt = sssp_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != sssp_pkg::ST_IDLE);
    case (state_r)
      sssp_pkg::ST_CLEAR:    cmd.clear_wr = 1'b1;
      sssp_pkg::ST_IDLE: begin
        cmd.write_edge = start && (opcode == sssp_pkg::OP_WRITE);
        cmd.run_init   = start && (opcode == sssp_pkg::OP_RUN);
      end
      sssp_pkg::ST_SCAN_CMP: cmd.scan_cmp  = 1'b1;
      sssp_pkg::ST_PICK:     cmd.pick      = 1'b1;
      sssp_pkg::ST_RLX_CMP:  cmd.relax_cmp = 1'b1;
      sssp_pkg::ST_OUT_EMIT: cmd.out_emit  = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hdl/sssp_dpath.sv =====
// datapath: weight and distance rams, flag vectors, index and best-node registers
module sssp_dpath #(
  parameter int MAX_NODES   = sssp_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sssp_pkg::in_item_t               in_word,
  input  logic                             cfg_valid,
  input  logic [sssp_pkg::CFG_W-1:0]       cfg_data,
  input  sssp_pkg::dp_cmd_t                cmd,
  output sssp_pkg::dp_sts_t                sts,
  output logic                             out_strobe,
  output sssp_pkg::out_item_t              out_word
);

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int DIST_W = WEIGHT_BITS + IDX_W;
  localparam int WA_W   = 2 * IDX_W;
  localparam int W_DEPTH = 1 << WA_W;
  localparam int WS_W   = WEIGHT_BITS + 1;
  localparam int DS_W   = IDX_W + DIST_W;
  localparam logic [sssp_pkg::OUT_DIST_W-1:0] OUT_MAX = '1;

  logic [sssp_pkg::CFG_W-1:0] node_count_r;
  logic [CNT_W-1:0]           n_r, n_eff;
  logic [IDX_W-1:0]           idx_r, best_r, src_idx;
  logic [DIST_W-1:0]          best_d_r;
  logic                       found_r;
  logic [MAX_NODES-1:0]       finite_r, settled_r;
  logic [WA_W-1:0]            clr_cnt_r;
  logic                       out_strobe_r;
  sssp_pkg::out_item_t        out_word_r, out_word_nxt;

  logic            w_we;
  logic [WA_W-1:0] w_waddr;
  logic [WS_W-1:0] w_wdata, w_rdata;
  logic            d_we;
  logic [IDX_W-1:0] d_waddr;
  logic [DS_W-1:0] d_wdata, d_rdata;

  logic [DIST_W-1:0]      d_rd, cand;
  logic [IDX_W-1:0]       p_rd;
  logic                   w_present;
  logic [WEIGHT_BITS-1:0] w_val, w_in;
  logic                   wr_ok, src_ok, idx_last, cand_ok, upd, sat;

  // clamp of the node count register
  always_comb begin
    if (node_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(node_count_r) > MAX_NODES) begin
      n_eff = CNT_W'(MAX_NODES);
    end else begin
      n_eff = CNT_W'(node_count_r);
    end
  end

  assign src_ok   = 32'(in_word.source_node) < 32'(n_eff);
  assign src_idx  = IDX_W'(in_word.source_node);
  assign wr_ok    = (32'(in_word.from_node) < MAX_NODES) && (32'(in_word.to_node) < MAX_NODES);
  assign idx_last = (32'(idx_r) + 32'd1) == 32'(n_r);
  assign w_in     = WEIGHT_BITS'(in_word.edge_weight);

  assign d_rd      = d_rdata[DIST_W-1:0];
  assign p_rd      = d_rdata[DS_W-1:DIST_W];
  assign w_present = w_rdata[WEIGHT_BITS];
  assign w_val     = w_rdata[WEIGHT_BITS-1:0];
  assign cand      = best_d_r + DIST_W'(w_val);

  assign cand_ok = finite_r[idx_r] && !settled_r[idx_r];
  assign upd     = cmd.relax_cmp && (idx_r != best_r) && !settled_r[idx_r] && w_present
                   && (!finite_r[idx_r] || cand < d_rd);

  // weight store
  always_comb begin
    if (cmd.clear_wr) begin
      w_we    = 1'b1;
      w_waddr = clr_cnt_r;
      w_wdata = '0;
    end else begin
      w_we    = cmd.write_edge && wr_ok;
      w_waddr = {IDX_W'(in_word.from_node), IDX_W'(in_word.to_node)};
      w_wdata = {in_word.edge_present, in_word.edge_present ? w_in : {WEIGHT_BITS{1'b0}}};
    end
  end

  sssp_ram #(.WIDTH(WS_W), .DEPTH(W_DEPTH)) u_wram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr ({best_r, idx_r}),
    .rdata (w_rdata)
  );

  // distance and predecessor store
  always_comb begin
    if (cmd.run_init) begin
      d_we    = src_ok;
      d_waddr = src_idx;
      d_wdata = {src_idx, {DIST_W{1'b0}}};
    end else begin
      d_we    = upd;
      d_waddr = idx_r;
      d_wdata = {best_r, cand};
    end
  end

  sssp_ram #(.WIDTH(DS_W), .DEPTH(MAX_NODES)) u_dram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (idx_r),
    .rdata (d_rdata)
  );

  // result formatting
  assign sat = {{sssp_pkg::OUT_DIST_W{1'b0}}, d_rd} > {{DIST_W{1'b0}}, OUT_MAX};

  always_comb begin
    out_word_nxt.node_id     = sssp_pkg::NODE_W'(idx_r);
    out_word_nxt.reachable   = finite_r[idx_r];
    out_word_nxt.last_result = idx_last;
    if (finite_r[idx_r]) begin
      out_word_nxt.distance    = sat ? OUT_MAX : sssp_pkg::OUT_DIST_W'(d_rd);
      out_word_nxt.predecessor = sssp_pkg::NODE_W'(p_rd);
    end else begin
      out_word_nxt.distance    = '0;
      out_word_nxt.predecessor = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= sssp_pkg::NODE_COUNT_RST;
      n_r          <= CNT_W'(1);
      idx_r        <= '0;
      found_r      <= 1'b0;
      finite_r     <= '0;
      settled_r    <= '0;
      clr_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.out_emit;
      if (cfg_valid) node_count_r <= cfg_data;
      if (cmd.clear_wr) clr_cnt_r <= clr_cnt_r + WA_W'(1);
      if (cmd.run_init) begin
        n_r       <= n_eff;
        idx_r     <= '0;
        found_r   <= 1'b0;
        settled_r <= '0;
        // only the source starts with a finite distance
        finite_r  <= {{(MAX_NODES-1){1'b0}}, src_ok} << src_idx;
      end
      if (cmd.scan_cmp || cmd.relax_cmp || cmd.out_emit) begin
        idx_r <= idx_last ? '0 : idx_r + IDX_W'(1);
      end
      if (cmd.scan_cmp && cand_ok && (!found_r || d_rd < best_d_r)) found_r <= 1'b1;
      if (cmd.pick && found_r) settled_r[best_r] <= 1'b1;
      if (cmd.relax_cmp && idx_last) found_r <= 1'b0;
      if (upd) finite_r[idx_r] <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.scan_cmp && cand_ok && (!found_r || d_rd < best_d_r)) begin
      best_r   <= idx_r;
      best_d_r <= d_rd;
    end
    if (cmd.out_emit) out_word_r <= out_word_nxt;
  end

  assign sts.clear_done = &clr_cnt_r;
  assign sts.src_ok     = src_ok;
  assign sts.found      = found_r;
  assign sts.idx_last   = idx_last;

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

// ===== hdl/single_source_shortest_paths_core.sv =====
// shortest path core: dense weight matrix store and sequential dijkstra engine
// a write word is taken straight from idle and busy stays low
// a run word keeps busy high once taken, and no further word is taken until it ends;
//   a source outside the nodes in use goes straight to the result output
// results come out registered and cannot be held off
// synchronous active-low reset, then a clearing pass empties the whole weight matrix
//   while busy is high
module single_source_shortest_paths_core #(
  parameter int MAX_NODES   = sssp_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  sssp_pkg::in_item_t         in_word,
  // result channel
  output logic                       out_strobe,
  output sssp_pkg::out_item_t        out_word,
  // node count register
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sssp_pkg::CFG_W-1:0] cfg_data
);

  sssp_pkg::dp_cmd_t cmd;
  sssp_pkg::dp_sts_t sts;

  // a run copies the node count when it starts, so a write is always taken
  assign cfg_ready = 1'b1;

  // controller: walks clear, scan, pick, relax and output phases
  sssp_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_word.opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  // datapath: matrix ram, distance ram, settled and finite flags, output register
  sssp_dpath #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

// ===== hdl/sssp_checker.sv =====
// port-level checks for the shortest path core, bound to the top level
module sssp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input sssp_pkg::in_item_t  in_word,
  input logic                out_strobe,
  input sssp_pkg::out_item_t out_word
);

  // a run word always occupies the engine
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_word.opcode == sssp_pkg::OP_RUN |=> busy)
    else $error("run word did not raise busy");

  // a matrix write never raises busy
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_word.opcode == sssp_pkg::OP_WRITE |=> !busy)
    else $error("write word raised busy");

  // results only follow a busy cycle
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result word without a run in progress");

  // nothing follows the last result directly
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.last_result |=> !out_strobe)
    else $error("result word after the last one");

endmodule

bind single_source_shortest_paths_core sssp_checker u_sssp_checker (.*);

// ===== tb/shortest_path_checker.sv =====
// checker for the shortest path core: keeps its own weight matrix and predicts every result word
`timescale 1ns / 100ps
module shortest_path_checker
  import sssp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  in_item_t          in_word,
  input  logic              out_strobe,
  input  out_item_t         out_word,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                fail_count,
  output int                pending_words,
  output int                results_checked
);

  localparam int        NODES    = MAX_NODES_DEF;
  localparam bit [31:0] DIST_CAP = (32'd1 << OUT_DIST_W) - 1;

  bit                   edge_on  [NODES][NODES];
  bit [WEIGHT_IN_W-1:0] edge_len [NODES][NODES];
  bit [CFG_W-1:0]       node_count_reg;
  out_item_t            path_results_due [$];

  // zero acts as one node, anything above the matrix size as the full matrix
  function automatic int unsigned nodes_in_use();
    if (node_count_reg == 0) return 1;
    if (node_count_reg > NODES) return NODES;
    return node_count_reg;
  endfunction

  function automatic void predict_path_results(input logic [NODE_W-1:0] src);
    int unsigned     n;
    int              best, i, j;
    bit              found;
    bit [31:0]       cand;
    bit [31:0]       path_len [NODES];
    bit              reached  [NODES];
    bit              settled  [NODES];
    bit [NODE_W-1:0] prev     [NODES];
    out_item_t       r;
    n = nodes_in_use();
    for (i = 0; i < NODES; i++) begin
      path_len[i] = 0;
      reached[i]  = 0;
      settled[i]  = 0;
      prev[i]     = 0;
    end
    found = (src < n);
    if (found) begin
      reached[src] = 1;
      prev[src]    = src;
    end
    // settle the nearest open node, lowest index on ties, then relax its row
    while (found) begin
      found = 0;
      best  = 0;
      for (i = 0; i < n; i++)
        if (!settled[i] && reached[i] && (!found || path_len[i] < path_len[best])) begin
          best  = i;
          found = 1;
        end
      if (found) begin
        settled[best] = 1;
        for (j = 0; j < n; j++)
          if (j != best && !settled[j] && edge_on[best][j]) begin
            cand = path_len[best] + edge_len[best][j];
            if (!reached[j] || cand < path_len[j]) begin
              path_len[j] = cand;
              reached[j]  = 1;
              prev[j]     = NODE_W'(best);
            end
          end
      end
    end
    for (i = 0; i < n; i++) begin
      r.node_id     = NODE_W'(i);
      r.reachable   = reached[i];
      r.distance    = !reached[i] ? '0 :
                      (path_len[i] > DIST_CAP) ? '1 : path_len[i][OUT_DIST_W-1:0];
      r.predecessor = reached[i] ? prev[i] : '0;
      r.last_result = (i == n - 1);
      path_results_due.insert(path_results_due.size(), r);
    end
  endfunction

  function automatic void check_field(string name, int node, int unsigned want,
                                      int unsigned got);
    if (want != got) begin
      $error("%s of node %0d: expected %0d, got %0d", name, node, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int a = 0; a < NODES; a++)
        for (int b = 0; b < NODES; b++) begin
          edge_on[a][b]  = 0;
          edge_len[a][b] = '0;
        end
      node_count_reg = NODE_COUNT_RST;
      path_results_due.delete();
    end else begin
      if (out_strobe) begin
        if (path_results_due.size() == 0) begin
          $error("result word for node %0d with none expected", out_word.node_id);
          fail_count++;
        end else begin
          want = path_results_due.pop_front();
          results_checked++;
          check_field("node_id", want.node_id, want.node_id, out_word.node_id);
          check_field("distance", want.node_id, want.distance, out_word.distance);
          check_field("reachable", want.node_id, want.reachable, out_word.reachable);
          check_field("predecessor", want.node_id, want.predecessor, out_word.predecessor);
          check_field("last_result", want.node_id, want.last_result, out_word.last_result);
        end
      end
      if (start && !busy) begin
        if (in_word.opcode == OP_WRITE) begin
          edge_on[in_word.from_node][in_word.to_node]  = in_word.edge_present;
          edge_len[in_word.from_node][in_word.to_node] =
            in_word.edge_present ? in_word.edge_weight : '0;
        end else begin
          predict_path_results(in_word.source_node);
        end
      end
      if (cfg_valid && cfg_ready) node_count_reg = cfg_data;
    end
    pending_words <= path_results_due.size();
  end

endmodule

// ===== tb/single_source_shortest_paths_core_tb.sv =====
// testbench top for the shortest path core: stimulus, idling and final verdict
`timescale 1ns / 100ps
module single_source_shortest_paths_core_tb;
  import sssp_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_item_t         in_word;
  logic             out_strobe;
  out_item_t        out_word;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  // counters handed up by the checker
  int fail_count;
  int pending_words;
  int results_checked;

  // stimulus bookkeeping
  int          words_sent;
  int          runs_sent;
  int          settings_written;
  int          burst_left;
  int unsigned nodes_active;

  single_source_shortest_paths_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  shortest_path_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_word         (in_word),
    .out_strobe      (out_strobe),
    .out_word        (out_word),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_words   (pending_words),
    .results_checked (results_checked)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // fully random word, used as filler for the fields an operation ignores
  function automatic in_item_t random_word();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  // weights lean towards small values so that ties and detours happen,
  // with zero and the full-scale weight mixed in
  function automatic int pick_weight();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 65535;
      2, 3:    return $urandom_range(0, 65535);
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  // drop start for a number of cycles; never called with zero so that start
  // does not get two assignments in one step
  task automatic pause_sender(int cycles);
    start   <= 1'b0;
    in_word <= random_word();
    repeat (cycles) @(posedge clk);
  endtask

  // offer one word and hold it until the core takes it (start high, busy low)
  task automatic send_word(in_item_t w);
    if (burst_left == 0) begin
      // most bursts start after a gap, now and then a long one
      if ($urandom_range(0, 3) != 0)
        pause_sender($urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 6));
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    words_sent++;
    if (w.opcode == OP_RUN) runs_sent++;
  endtask

  task automatic send_edge(int from, int to, int weight, bit present);
    in_item_t w;
    w              = random_word();
    w.opcode       = OP_WRITE;
    w.from_node    = NODE_W'(from);
    w.to_node      = NODE_W'(to);
    w.edge_weight  = WEIGHT_IN_W'(weight);
    w.edge_present = present;
    send_word(w);
  endtask

  task automatic send_run(int src);
    in_item_t w;
    w             = random_word();
    w.opcode      = OP_RUN;
    w.source_node = NODE_W'(src);
    send_word(w);
  endtask

  // hold off until every predicted word has come back and the core is idle
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_words != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  // node count only changes while nothing is in flight
  task automatic set_node_count(int value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= CFG_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    nodes_active = (value == 0) ? 1 : (value > MAX_NODES_DEF) ? MAX_NODES_DEF : value;
    settings_written++;
  endtask

  // mostly edges among the nodes in use so that runs find real paths; the
  // rest are stray entries anywhere in the matrix and runs, some from any source
  task automatic random_traffic(int words);
    repeat (words) begin
      if ($urandom_range(0, 49) == 0) wait_drained();
      if ($urandom_range(0, 4) == 0)
        send_run(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                             : $urandom_range(0, nodes_active - 1));
      else if ($urandom_range(0, 6) == 0)
        send_edge($urandom_range(0, 31), $urandom_range(0, 31), pick_weight(),
                  $urandom_range(0, 1));
      else
        send_edge($urandom_range(0, nodes_active - 1), $urandom_range(0, nodes_active - 1),
                  pick_weight(), $urandom_range(0, 7) != 0);
    end
  endtask

  initial begin
    int k, p, count;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_word      <= '0;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    burst_left   = 0;
    nodes_active = NODE_COUNT_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, all 32 nodes in use after reset
    send_edge(0, 1, 0, 1);          // zero weight edge
    send_edge(1, 2, 65535, 1);
    send_edge(0, 2, 65535, 1);      // equal cost path, first one found must stay
    send_edge(2, 2, 5, 1);          // self edge is ignored
    send_edge(2, 3, 3, 1);
    send_edge(3, 4, 9, 1);
    send_edge(3, 4, 9, 0);          // rewritten as absent
    send_edge(2, 4, 100, 1);
    send_edge(2, 4, 1, 1);          // later weight replaces the earlier one
    send_edge(31, 30, 1, 1);
    send_edge(4, 31, 65535, 1);
    send_edge(30, 0, 65535, 0);     // absent entry carrying a weight
    send_run(0);
    send_run(31);
    send_run(17);                   // isolated source
    set_node_count(0);              // acts as a single node
    send_run(0);
    send_run(31);                   // source outside the nodes in use
    set_node_count(63);             // clamps to the full matrix
    send_run(2);
    set_node_count(4);
    send_edge(0, 20, 1, 1);         // path through a node not in use
    send_edge(20, 3, 1, 1);
    send_edge(3, 2, 0, 1);
    send_run(3);
    send_run(4);
    set_node_count(1);
    send_run(0);

    // long chain over every node, pushes distances towards the top of the field
    set_node_count(32);
    for (k = 0; k < 31; k++) send_edge(k, k + 1, $urandom_range(60000, 65535), 1);
    send_run(0);
    send_run($urandom_range(0, 31));

    // random phases, mostly small graphs so that runs stay short
    for (p = 0; p < 8; p++) begin
      case ($urandom_range(0, 9))
        0:       count = 32;
        1:       count = $urandom_range(33, 63);
        2, 3:    count = $urandom_range(10, 20);
        default: count = $urandom_range(2, 9);
      endcase
      set_node_count(count);
      random_traffic($urandom_range(35, 50));
    end

    // drain, then leave room for any stray result word
    wait_drained();
    repeat (40) @(posedge clk);

    $display("covered %0d command words, %0d of them path runs, over %0d node count settings",
             words_sent, runs_sent, settings_written);
    $display("%0d result words compared with the predicted shortest paths", results_checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog, 60 ms is far beyond the slowest legal run
  initial begin
    #60000000;
    $display("FAILURE");
    $finish;
  end

endmodule
